// ===== rtl/iss_pkg.sv =====
// ----------------------------------------------------------------------------
// iss_pkg: shared definitions for the indexed sequence store
// Command and status codes, store depth and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

   // Store geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = 5;
   localparam int POS_W = 5;
   localparam int VAL_W = 32;

   // Command codes
   typedef enum logic [3:0] {
      CMD_PUSH_BACK  = 4'd0,
      CMD_PUSH_FRONT = 4'd1,
      CMD_INSERT     = 4'd2,
      CMD_REMOVE     = 4'd3,
      CMD_READ       = 4'd4,
      CMD_POP_FRONT  = 4'd5,
      CMD_POP_BACK   = 4'd6,
      CMD_OVERWRITE  = 4'd7,
      CMD_CLEAR      = 4'd8
   } cmd_type;

   // Status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/indexed_sequence_store.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store: bounded ordered sequence of signed 32-bit values
// Compacted register array with parallel shift on insert and remove.
// ----------------------------------------------------------------------------
// The block holds up to 16 signed 32-bit values in order. Every command
// (push back/front, insert, remove, read, pop front/back, overwrite, clear)
// is decoded and applied to the register array in the cycle it is accepted,
// and its one result item (read value, status, count, empty flag) appears in
// the result register on the next cycle. One item is accepted every cycle
// while results are taken; the figure is set by the single result register,
// which frees up in the same cycle its item is taken. Inserts and removes
// shift all entries above the position at once, so their cost does not
// depend on the position. The store contents are not cleared at reset;
// only the count is, so no entry is ever read before it is written.
`default_nettype none

module indexed_sequence_store
   import iss_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [3:0]              req_cmd,
   input  wire logic signed [VAL_W-1:0] req_value,
   input  wire logic [POS_W-1:0]        req_position,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [VAL_W-1:0]      rsp_read_value,
   output logic [1:0]                   rsp_status,
   output logic [CNT_W-1:0]             rsp_count,
   output logic                         rsp_is_empty
);

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INS,
      OP_REM,
      OP_WR
   } op_type;

   logic [VAL_W-1:0]        elements_ff [DEPTH];
   logic [VAL_W-1:0]        elements_in [DEPTH];
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   logic [VAL_W-1:0]        rsp_read_value_ff;
   logic [VAL_W-1:0]        rsp_read_value_in;
   status_type              rsp_status_ff;
   status_type              rsp_status_in;
   logic [CNT_W-1:0]        rsp_count_ff;

   op_type                  op;
   logic [CNT_W-1:0]        op_pos;
   logic                    rd_en;
   logic [CNT_W-1:0]        rd_addr;
   logic                    req_fire;
   logic                    full;
   logic                    empty;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   // Decode the command into a store operation, status and new count
   always_comb begin
      op            = OP_NONE;
      op_pos        = req_position;
      rd_en         = 1'b0;
      rd_addr       = req_position;
      rsp_status_in = ST_OK;
      count_in      = count_ff;
      unique case (cmd_type'(req_cmd))
         CMD_PUSH_BACK: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               op       = OP_INS;
               op_pos   = count_ff;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               op       = OP_INS;
               op_pos   = '0;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_INSERT: begin
            if (req_position > count_ff) begin
               rsp_status_in = ST_BADPOS;
            end else if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               op       = OP_INS;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (empty && req_position == '0) begin
               rsp_status_in = ST_EMPTY;
            end else if (req_position >= count_ff) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               op       = OP_REM;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_READ: begin
            if (req_position >= count_ff) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               rd_en = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               op       = OP_REM;
               op_pos   = '0;
               rd_en    = 1'b1;
               rd_addr  = '0;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = count_ff - CNT_W'(1);
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_OVERWRITE: begin
            if (req_position >= count_ff) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               op = OP_WR;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            // unused codes leave everything as is
         end
      endcase
   end

   // Select the read entry; zero for every command that reads nothing
   assign rsp_read_value_in = rd_en ? elements_ff[rd_addr[IDX_W-1:0]] : '0;

   // Next value of each entry: shift up, shift down or overwrite
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      logic [VAL_W-1:0] below;
      logic [VAL_W-1:0] above;

      if (i == 0) begin : g_bottom
         assign below = req_value;
      end else begin : g_mid_lo
         assign below = elements_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_top
         assign above = elements_ff[i];
      end else begin : g_mid_hi
         assign above = elements_ff[i+1];
      end

      always_comb begin
         elements_in[i] = elements_ff[i];
         unique case (op)
            OP_INS: begin
               if (CNT_W'(i) > op_pos) begin
                  elements_in[i] = below;
               end else if (CNT_W'(i) == op_pos) begin
                  elements_in[i] = req_value;
               end
            end
            OP_REM: begin
               if (CNT_W'(i) >= op_pos) begin
                  elements_in[i] = above;
               end
            end
            OP_WR: begin
               if (CNT_W'(i) == op_pos) begin
                  elements_in[i] = req_value;
               end
            end
            OP_NONE: begin
               elements_in[i] = elements_ff[i];
            end
            default: begin
               elements_in[i] = elements_ff[i];
            end
         endcase
      end
   end

   // Update the store on an accepted item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < DEPTH; i++) begin
            elements_ff[i] <= elements_in[i];
         end
      end
   end

   // Hold the count and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_count_ff      <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = (rsp_count_ff == '0);

`ifndef SYNTHESIS
   // Count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count exceeds depth");

   // A failed command leaves the count untouched
   a_fail_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_status_in != ST_OK) |=> (count_ff == $past(count_ff)))
      else $error("failed command changed count");

   // A failed command returns zero read data
   a_fail_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_read_value_ff == '0))
      else $error("failed command returned data");

   // Result count matches the store count right after acceptance
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_count_ff == count_ff))
      else $error("result count differs from store count");
`endif

endmodule

`default_nettype wire
